FILE: hw/rtl/two_key_short_long_press_controller_core_assert.svh
// Assertion macros for the two-key press controller checker.
// Included by the checker file; needs nothing else.
`ifndef TWO_KEY_SHORT_LONG_PRESS_CONTROLLER_CORE_ASSERT_SVH
`define TWO_KEY_SHORT_LONG_PRESS_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define TKSLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TKSLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tkslp_pkg.sv
// Shared types and constants of the two-key press controller.
// No dependencies.
package tkslp_pkg;

  localparam int KEY_W      = 8;
  localparam int DEB_W      = 8;
  localparam int HOLD_W     = 10;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [DEB_W-1:0]  SHORT_MIN_DEBOUNCE = 8'd3;
  localparam logic [MODE_W:0]   FILTER_WRAP        = 4'd5;
  localparam logic [MODE_W-1:0] FILTER_FIRST       = 3'd1;
  localparam logic [MODE_W-1:0] FILTER_NONE        = 3'd0;

  localparam logic [KEY_W-1:0]  LEFT_KEY_RST   = 8'd1;
  localparam logic [KEY_W-1:0]  RIGHT_KEY_RST  = 8'd2;
  localparam logic [HOLD_W-1:0] LONG_TICKS_RST = 10'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_KEY  = 2'd0,
    CFG_RIGHT_KEY = 2'd1,
    CFG_LONG_TICKS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [KEY_W-1:0]  left_key_code;
    logic [KEY_W-1:0]  right_key_code;
    logic [HOLD_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic [DEB_W-1:0] debounce_count;
    logic             wash_active;
  } tick_t;

  typedef struct packed {
    logic              power_on;
    logic              filter_set_active;
    logic [MODE_W-1:0] filter_mode;
    logic              beep;
    logic              start_wash;
    logic              stop_wash;
  } result_t;

endpackage

FILE: hw/rtl/tkslp_if.sv
// Valid/ready channel interfaces: scan tick in, status result out.
// Depends on tkslp_pkg.
interface tkslp_tick_if import tkslp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;
  logic [DEB_W-1:0] debounce_count;
  logic             wash_active;

  modport source (output valid, key_code, debounce_count, wash_active, input ready);
  modport sink   (input valid, key_code, debounce_count, wash_active, output ready);
endinterface

interface tkslp_result_if import tkslp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              power_on;
  logic              filter_set_active;
  logic [MODE_W-1:0] filter_mode;
  logic              beep;
  logic              start_wash;
  logic              stop_wash;

  modport source (output valid, power_on, filter_set_active, filter_mode, beep,
                  start_wash, stop_wash, input ready);
  modport sink   (input valid, power_on, filter_set_active, filter_mode, beep,
                  start_wash, stop_wash, output ready);
endinterface

FILE: hw/rtl/two_key_short_long_press_controller_core.sv
// Top level of the two-key short/long press controller.
// Depends on tkslp_pkg, the channel interfaces and the tkslp_* stage modules.
//
//   channel  | dir | beat contents
//   ---------+-----+---------------------------------------------------------
//   tick     | in  | key_code, debounce_count, wash_active
//   result   | out | power_on, filter_set_active, filter_mode, beep,
//            |     | start_wash, stop_wash
//   cfg_*    | in  | cfg_index, cfg_data written when cfg_wr_en
//
// One beat per cycle while result is not stalled; a result is registered after tick
// accept (the press update runs from the input register into the result register).
// Synchronous active-high reset clears both stages and loads the press state.
// A stall on result holds the result register; the input register then fills
// and tick.ready drops.
module two_key_short_long_press_controller_core import tkslp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tkslp_tick_if.sink            tick,
  tkslp_result_if.source        result,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  tick_t   item;
  logic    item_valid;
  logic    out_free;
  logic    take;
  result_t res;

  assign take = item_valid && out_free;

  tkslp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tkslp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .take       (take),
    .item       (item),
    .item_valid (item_valid)
  );

  tkslp_press_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .fire (take),
    .res  (res)
  );

  tkslp_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (take),
    .res_in (res),
    .free   (out_free),
    .result (result)
  );

endmodule

FILE: hw/rtl/tkslp_cfg_regs.sv
// Configuration registers: key codes and long-press length.
// Depends on tkslp_pkg.
module tkslp_cfg_regs import tkslp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_key_code    <= LEFT_KEY_RST;
      cfg.right_key_code   <= RIGHT_KEY_RST;
      cfg.long_press_ticks <= LONG_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEFT_KEY:   cfg.left_key_code    <= cfg_data[KEY_W-1:0];
        CFG_RIGHT_KEY:  cfg.right_key_code   <= cfg_data[KEY_W-1:0];
        CFG_LONG_TICKS: cfg.long_press_ticks <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/tkslp_in_reg.sv
// Input register stage for scan tick beats.
// Depends on tkslp_pkg and tkslp_tick_if.
module tkslp_in_reg import tkslp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  tkslp_tick_if.sink    tick,
  input  logic          take,
  output tick_t         item,
  output logic          item_valid
);

  logic accept;

  assign tick.ready = !item_valid || take;
  assign accept     = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.key_code       <= tick.key_code;
      item.debounce_count <= tick.debounce_count;
      item.wash_active    <= tick.wash_active;
    end
  end

endmodule

FILE: hw/rtl/tkslp_press_core.sv
// Press state and one-tick update: short press on key change, long press on hold.
// Depends on tkslp_pkg.
module tkslp_press_core import tkslp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  tick_t   item,
  input  logic    fire,
  output result_t res
);

  typedef struct packed {
    logic [KEY_W-1:0]  last_key;
    logic              long_done;
    logic [HOLD_W-1:0] left_hold_count;
    logic [HOLD_W-1:0] right_hold_count;
    logic              power_state;
    logic              filter_set_flag;
    logic [MODE_W-1:0] filter_index;
  } press_state_t;

  press_state_t      st;
  press_state_t      st_next;
  logic [MODE_W:0]   idx_inc;
  logic [HOLD_W-1:0] left_inc;
  logic [HOLD_W-1:0] right_inc;
  logic              beep;
  logic              start_wash;
  logic              stop_wash;

  assign idx_inc   = {1'b0, st.filter_index} + {{MODE_W{1'b0}}, 1'b1};
  assign left_inc  = st.left_hold_count + {{(HOLD_W-1){1'b0}}, 1'b1};
  assign right_inc = st.right_hold_count + {{(HOLD_W-1){1'b0}}, 1'b1};

  always_comb begin
    st_next    = st;
    beep       = 1'b0;
    start_wash = 1'b0;
    stop_wash  = 1'b0;
    if (item.key_code != st.last_key && item.debounce_count > SHORT_MIN_DEBOUNCE) begin
      // short press of the key just released
      if (st.last_key == cfg.left_key_code && !st.long_done) begin
        if (st.filter_set_flag) begin
          beep = 1'b1;
          st_next.filter_index = (idx_inc >= FILTER_WRAP) ? FILTER_FIRST
                                                          : idx_inc[MODE_W-1:0];
        end
      end else if (st.last_key == cfg.right_key_code && !st.long_done) begin
        beep = 1'b1;
        if (!st.power_state) begin
          st_next.power_state = 1'b1;
          start_wash = 1'b1;
        end else if (item.wash_active) begin
          stop_wash = 1'b1;
        end else begin
          start_wash = 1'b1;
        end
      end
      st_next.last_key  = item.key_code;
      st_next.long_done = 1'b0;
    end else begin
      // hold tick: left counter first, then right
      if (item.key_code == cfg.left_key_code) begin
        if (left_inc >= cfg.long_press_ticks) begin
          st_next.left_hold_count = '0;
          beep = 1'b1;
          st_next.long_done = 1'b1;
          if (!st.filter_set_flag) begin
            st_next.filter_set_flag = 1'b1;
            st_next.filter_index    = FILTER_FIRST;
          end else begin
            st_next.filter_set_flag = 1'b0;
            st_next.filter_index    = FILTER_NONE;
          end
        end else begin
          st_next.left_hold_count = left_inc;
        end
      end else begin
        st_next.left_hold_count = '0;
      end
      if (item.key_code == cfg.right_key_code) begin
        if (right_inc >= cfg.long_press_ticks) begin
          st_next.right_hold_count = '0;
          if (st.power_state) begin
            beep = 1'b1;
            st_next.power_state = 1'b0;
            st_next.long_done   = 1'b1;
          end
        end else begin
          st_next.right_hold_count = right_inc;
        end
      end else begin
        st_next.right_hold_count = '0;
      end
    end
  end

  always_comb begin
    res.power_on          = st_next.power_state;
    res.filter_set_active = st_next.filter_set_flag;
    res.filter_mode       = st_next.filter_index;
    res.beep              = beep;
    res.start_wash        = start_wash;
    res.stop_wash         = stop_wash;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.last_key         <= '0;
      st.long_done        <= 1'b0;
      st.left_hold_count  <= '0;
      st.right_hold_count <= '0;
      st.power_state      <= 1'b1;
      st.filter_set_flag  <= 1'b0;
      st.filter_index     <= FILTER_FIRST;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

FILE: hw/rtl/tkslp_out_reg.sv
// Result register stage driving the output channel.
// Depends on tkslp_pkg and tkslp_result_if.
module tkslp_out_reg import tkslp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  result_t         res_in,
  output logic            free,
  tkslp_result_if.source  result
);

  logic    res_valid;
  result_t res_q;

  assign free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

  assign result.valid             = res_valid;
  assign result.power_on          = res_q.power_on;
  assign result.filter_set_active = res_q.filter_set_active;
  assign result.filter_mode       = res_q.filter_mode;
  assign result.beep              = res_q.beep;
  assign result.start_wash        = res_q.start_wash;
  assign result.stop_wash         = res_q.stop_wash;

endmodule

FILE: hw/rtl/tkslp_checker.sv
// Port-level checks on the result channel of the press controller.
// Depends on tkslp_pkg and the assertion macro header; bound to the top level.
`include "two_key_short_long_press_controller_core_assert.svh"

module tkslp_checker import tkslp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic              power_on,
  input logic              filter_set_active,
  input logic [MODE_W-1:0] filter_mode,
  input logic              beep,
  input logic              start_wash,
  input logic              stop_wash
);

  `TKSLP_ASSERT_NEXT(a_stall_hold, clk, rst, res_valid && !res_ready, res_valid && $stable({power_on, filter_set_active, filter_mode, beep, start_wash, stop_wash}), "result beat changed while stalled")
  `TKSLP_ASSERT_NOW(a_wash_excl, clk, rst, res_valid, !(start_wash && stop_wash), "start and stop wash together")
  `TKSLP_ASSERT_NOW(a_wash_beep, clk, rst, res_valid && (start_wash || stop_wash), beep && power_on, "wash request without beep or power")
  `TKSLP_ASSERT_NOW(a_set_mode, clk, rst, res_valid && filter_set_active, filter_mode != FILTER_NONE && filter_mode < 3'd5, "set mode with bad filter index")

endmodule

bind two_key_short_long_press_controller_core tkslp_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .power_on          (result.power_on),
  .filter_set_active (result.filter_set_active),
  .filter_mode       (result.filter_mode),
  .beep              (result.beep),
  .start_wash        (result.start_wash),
  .stop_wash         (result.stop_wash)
);

FILE: verif/two_key_short_long_press_controller_core_checker.sv
// Checker for the two-key press controller: watches tick, result and config traffic,
// predicts each status beat and compares it field by field.
// Depends on tkslp_pkg and the channel interfaces in tkslp_if.sv.
module two_key_short_long_press_controller_core_checker import tkslp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tkslp_tick_if                 tick_mon,
  tkslp_result_if               result_mon,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  cfg_t              key_cfg;
  logic [KEY_W-1:0]  held_key;
  logic              long_fired;
  logic [HOLD_W-1:0] left_hold;
  logic [HOLD_W-1:0] right_hold;
  logic              powered;
  logic              set_mode;
  logic [MODE_W-1:0] filt_idx;
  result_t           status_q[$];

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic predict_status(input tick_t t);
    result_t           r;
    logic [HOLD_W-1:0] cnt;
    logic [MODE_W:0]   idx_up;
    r = '0;
    if (t.key_code != held_key && t.debounce_count > SHORT_MIN_DEBOUNCE) begin
      // key changed: short action of the key released
      if (held_key == key_cfg.left_key_code && !long_fired) begin
        if (set_mode) begin
          r.beep = 1'b1;
          idx_up = {1'b0, filt_idx} + 1'b1;
          filt_idx = (idx_up >= FILTER_WRAP) ? FILTER_FIRST : idx_up[MODE_W-1:0];
        end
      end else if (held_key == key_cfg.right_key_code && !long_fired) begin
        r.beep = 1'b1;
        if (!powered) begin
          powered = 1'b1;
          r.start_wash = 1'b1;
        end else if (t.wash_active) begin
          r.stop_wash = 1'b1;
        end else begin
          r.start_wash = 1'b1;
        end
      end
      held_key = t.key_code;
      long_fired = 1'b0;
    end else begin
      if (t.key_code == key_cfg.left_key_code) begin
        cnt = left_hold + 1'b1;
        if (cnt >= key_cfg.long_press_ticks) begin
          left_hold = '0;
          r.beep = 1'b1;
          long_fired = 1'b1;
          if (!set_mode) begin
            set_mode = 1'b1;
            filt_idx = FILTER_FIRST;
          end else begin
            set_mode = 1'b0;
            filt_idx = FILTER_NONE;
          end
        end else begin
          left_hold = cnt;
        end
      end else begin
        left_hold = '0;
      end
      if (t.key_code == key_cfg.right_key_code) begin
        cnt = right_hold + 1'b1;
        if (cnt >= key_cfg.long_press_ticks) begin
          right_hold = '0;
          if (powered) begin
            r.beep = 1'b1;
            powered = 1'b0;
            long_fired = 1'b1;
          end
        end else begin
          right_hold = cnt;
        end
      end else begin
        right_hold = '0;
      end
    end
    r.power_on = powered;
    r.filter_set_active = set_mode;
    r.filter_mode = filt_idx;
    status_q.push_back(r);
  endtask

  always @(posedge clk) begin : watch_p
    tick_t   t;
    result_t got;
    result_t want;
    if (rst) begin
      key_cfg.left_key_code = LEFT_KEY_RST;
      key_cfg.right_key_code = RIGHT_KEY_RST;
      key_cfg.long_press_ticks = LONG_TICKS_RST;
      held_key = '0;
      long_fired = 1'b0;
      left_hold = '0;
      right_hold = '0;
      powered = 1'b1;
      set_mode = 1'b0;
      filt_idx = FILTER_FIRST;
      status_q.delete();
      fail_count = 0;
    end else begin
      if (tick_mon.valid && tick_mon.ready) begin
        t.key_code = tick_mon.key_code;
        t.debounce_count = tick_mon.debounce_count;
        t.wash_active = tick_mon.wash_active;
        predict_status(t);
      end
      if (result_mon.valid && result_mon.ready) begin
        got.power_on = result_mon.power_on;
        got.filter_set_active = result_mon.filter_set_active;
        got.filter_mode = result_mon.filter_mode;
        got.beep = result_mon.beep;
        got.start_wash = result_mon.start_wash;
        got.stop_wash = result_mon.stop_wash;
        if (status_q.size() == 0) begin
          $display("%0t: result beat with no tick pending, got %h", $time, got);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          check_field("power_on", int'(want.power_on), int'(got.power_on));
          check_field("filter_set_active", int'(want.filter_set_active),
                      int'(got.filter_set_active));
          check_field("filter_mode", int'(want.filter_mode), int'(got.filter_mode));
          check_field("beep", int'(want.beep), int'(got.beep));
          check_field("start_wash", int'(want.start_wash), int'(got.start_wash));
          check_field("stop_wash", int'(want.stop_wash), int'(got.stop_wash));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LEFT_KEY:   key_cfg.left_key_code = cfg_data[KEY_W-1:0];
          CFG_RIGHT_KEY:  key_cfg.right_key_code = cfg_data[KEY_W-1:0];
          CFG_LONG_TICKS: key_cfg.long_press_ticks = cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end
    end
    pending = status_q.size();
  end

endmodule

FILE: verif/two_key_short_long_press_controller_core_tb.sv
// Testbench top for the two-key press controller: clock, reset, config phases,
// directed and random scan ticks with bursty sender and stalling receiver, verdict.
// Depends on tkslp_pkg, tkslp_if.sv, the core and the checker module.
module two_key_short_long_press_controller_core_tb import tkslp_pkg::*;;

  localparam int                   WATCHDOG_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_TOGGLE, RX_BURSTY} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  int       cur_left;
  int       cur_right;
  int       cur_long;
  int       burst_left;
  int       beats_sent;
  int       idle_cycles = 0;
  logic     rx_ready = 1'b0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_stall = 0;

  tkslp_tick_if   tick_ch();
  tkslp_result_if result_ch();

  assign result_ch.ready = rx_ready;

  two_key_short_long_press_controller_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  two_key_short_long_press_controller_core_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .tick_mon   (tick_ch),
    .result_mon (result_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(64, 256);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   rx_ready <= 1'b1;
      RX_RANDOM: rx_ready <= ($urandom_range(0, 9) < 7);
      RX_TOGGLE: rx_ready <= ~rx_ready;
      default: begin
        if (rx_stall != 0) begin
          rx_ready <= 1'b0;
          rx_stall <= rx_stall - 1;
        end else begin
          rx_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall <= $urandom_range(10, 40);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_keys(input int left, input int right, input int longt);
    logic [1:0]            hi_l;
    logic [1:0]            hi_r;
    logic [CFG_DATA_W-1:0] junk;
    hi_l = 2'($urandom_range(0, 3));
    hi_r = 2'($urandom_range(0, 3));
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_SPARE, junk);
    write_reg(CFG_LEFT_KEY, {hi_l, left[7:0]});
    write_reg(CFG_RIGHT_KEY, {hi_r, right[7:0]});
    write_reg(CFG_LONG_TICKS, longt[9:0]);
    cur_left = left;
    cur_right = right;
    cur_long = longt;
  endtask

  task automatic send_beat(input logic [7:0] key, input logic [7:0] deb, input logic wash);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        9:       gap = $urandom_range(5, 20);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap != 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    tick_ch.valid          <= 1'b1;
    tick_ch.key_code       <= key;
    tick_ch.debounce_count <= deb;
    tick_ch.wash_active    <= wash;
    do @(posedge clk); while (!tick_ch.ready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return cur_left[7:0];
      4, 5, 6, 7: return cur_right[7:0];
      8:          return 8'd0;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_hold();
    if (cur_long > 64) begin
      if (cur_long <= 300 && $urandom_range(0, 15) == 0) return cur_long + $urandom_range(0, 1);
      return $urandom_range(1, 15);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 15);
      6, 7, 8:          return ((cur_long > 1) ? cur_long - 1 : 1) + $urandom_range(0, 2);
      default:          return 2 * cur_long + $urandom_range(0, 1);
    endcase
  endfunction

  task automatic send_press(input logic [7:0] key, input int hold);
    logic [7:0] deb;
    int         i;
    deb = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(4, 255));
    send_beat(key, deb, 1'($urandom_range(0, 1)));
    for (i = 0; i < hold; i++)
      send_beat(key, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: send_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        1: send_beat(pick_key(), 8'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        default: begin
          send_press(pick_key(), pick_hold());
          if ($urandom_range(0, 3) != 0)
            send_beat(8'd0, 8'($urandom_range(4, 255)), 1'($urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  initial begin : stim_p
    int i;
    tick_ch.valid          = 1'b0;
    tick_ch.key_code       = '0;
    tick_ch.debounce_count = '0;
    tick_ch.wash_active    = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = CFG_LEFT_KEY;
    cfg_data   = '0;
    rst        = 1'b1;
    burst_left = 0;
    beats_sent = 0;
    cur_left   = LEFT_KEY_RST;
    cur_right  = RIGHT_KEY_RST;
    cur_long   = LONG_TICKS_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: short presses, debounce boundary, wash start/stop
    send_beat(8'd0, 8'd255, 1'b0);
    send_beat(8'd1, 8'd4, 1'b0);
    send_beat(8'd0, 8'd200, 1'b0);
    send_beat(8'd2, 8'd255, 1'b0);
    send_beat(8'd0, 8'd4, 1'b0);
    send_beat(8'd2, 8'd10, 1'b1);
    send_beat(8'd0, 8'd10, 1'b1);
    send_beat(8'd1, 8'd3, 1'b0);
    send_beat(8'd2, 8'd0, 1'b1);
    send_beat(8'd255, 8'd255, 1'b1);
    send_beat(8'd0, 8'd5, 1'b0);
    send_beat(8'd128, 8'd4, 1'b1);
    send_beat(8'd127, 8'd99, 1'b0);
    send_beat(8'd0, 8'd4, 1'b0);
    run_random(60);
    drain();

    set_keys(3, 4, 5);
    run_random(150);
    drain();

    set_keys(0, 255, 1);
    run_random(200);
    drain();

    // shared code for both keys
    set_keys(8'h5A, 8'h5A, 3);
    run_random(200);
    drain();

    set_keys(1, 2, 0);
    run_random(80);
    drain();

    // longest hold: long press toggles set mode, then one short step
    set_keys(8'h81, 8'h7E, 1023);
    send_beat(8'h81, 8'd200, 1'b0);
    for (i = 0; i < 1023; i++) send_beat(8'h81, 8'($urandom_range(0, 255)), 1'b0);
    send_beat(8'd0, 8'd9, 1'b0);
    send_beat(8'h81, 8'd4, 1'b1);
    send_beat(8'd0, 8'd4, 1'b1);
    run_random(40);
    drain();

    set_keys(1, 2, 20);
    run_random(80);
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
